>>> rtl/sssd_pkg.sv
// Shared types, mode codes and glyph constants for the seven-segment scan driver.
package sssd_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [7:0] seg_t;

  localparam mode_t MODE_WORKING  = 3'd0;
  localparam mode_t MODE_PREHEAT  = 3'd1;
  localparam mode_t MODE_SET_ONE  = 3'd2;
  localparam mode_t MODE_SET_TWO  = 3'd3;
  localparam mode_t MODE_DEBUG    = 3'd4;

  localparam seg_t MIRROR_MASK    = 8'b1100_0000;
  localparam seg_t POINT_KEEP     = 8'd127;
  localparam seg_t FALLBACK_GLYPH = 8'b1011_0110;
  localparam seg_t MARKER_ONE     = 8'b1111_1110;
  localparam seg_t MARKER_TWO     = 8'b1111_0111;
  localparam seg_t BLANK_GLYPH    = 8'hFF;

  localparam int unsigned PHASE_LAST = 5;

  // Active-low glyph for one decimal digit; anything above nine shows the fallback.
  function automatic seg_t glyph_of(input logic [3:0] d);
    seg_t g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hD8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = FALLBACK_GLYPH;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/seven_segment_scan_driver.sv
// Three-digit multiplexed seven-segment scan driver with preheat animation.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_shown_value, in_view_mode
//   out     | output    | out_valid/out_stall| out_segment_byte, out_select_byte,
//           |           |                    | out_ports_written
//
// One beat per cycle unless stalled: a tick is decoded between the input ports and the
// result register, and its beat appears in the cycle after acceptance. The digit split
// (constant reciprocal multiply and shift-add corrections) and the glyph lookup set the
// path into the result register. in_stall follows out_stall only while a result beat is
// held, so a new tick is taken in the same cycle a held beat leaves. Synchronous
// active-low reset clears digit position, animation state and the held port values.
module seven_segment_scan_driver #(
  parameter int unsigned ANIM_DIVIDE = 70
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_shown_value,
  input  sssd_pkg::mode_t     in_view_mode,
  output logic                out_valid,
  input  logic                out_stall,
  output sssd_pkg::seg_t      out_segment_byte,
  output sssd_pkg::seg_t      out_select_byte,
  output logic                out_ports_written
);
  import sssd_pkg::*;

  localparam logic [6:0] ANIM_LIMIT = 7'(ANIM_DIVIDE);

  logic [1:0] digit_r, digit_nxt;
  logic [6:0] prescale_r, prescale_nxt;
  logic [2:0] phase_r, phase_nxt;
  seg_t       seg_hold_r, seg_hold_nxt;
  seg_t       sel_hold_r, sel_hold_nxt;
  logic       written_r, written_nxt;
  logic       out_valid_r;

  logic        accept;
  logic [32:0] quot_prod;
  logic [9:0]  hundreds;
  logic [15:0] rem_full;
  logic [6:0]  rem100;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;
  seg_t        hund_glyph;
  seg_t        seg_new;
  seg_t        sel_onehot;
  logic        mode_known;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Split the value: hundreds by reciprocal, then tens and units from the remainder.
  always_comb begin
    quot_prod  = 33'(in_shown_value) * 33'd83887;
    hundreds   = quot_prod[32:23];
    rem_full   = in_shown_value - 16'({hundreds, 6'b0} + {1'b0, hundreds, 5'b0}
                                      + {4'b0, hundreds, 2'b0});
    rem100     = rem_full[6:0];
    tens_prod  = {1'b0, rem100, 7'b0} + {2'b0, rem100, 6'b0} + {5'b0, rem100, 3'b0}
                 + {6'b0, rem100, 2'b0} + {8'b0, rem100};
    tens       = tens_prod[14:11];
    tens_x10   = {tens, 3'b0} + {2'b0, tens, 1'b0};
    units      = 4'(rem100 - tens_x10);
    hund_glyph = (in_shown_value >= 16'd1000) ? FALLBACK_GLYPH : glyph_of(hundreds[3:0]);
  end

  always_comb begin
    prescale_nxt = prescale_r;
    phase_nxt    = phase_r;
    if (in_view_mode == MODE_PREHEAT) begin
      if (prescale_r > ANIM_LIMIT) begin
        prescale_nxt = '0;
        phase_nxt    = (phase_r < 3'(PHASE_LAST)) ? phase_r + 3'd1 : 3'd0;
      end else begin
        prescale_nxt = prescale_r + 7'd1;
      end
    end

    unique case (in_view_mode)
      MODE_WORKING, MODE_PREHEAT, MODE_SET_ONE, MODE_SET_TWO, MODE_DEBUG:
        mode_known = 1'b1;
      default:
        mode_known = 1'b0;
    endcase

    unique case (digit_r)
      2'd2:    seg_new = glyph_of(tens);
      2'd3:    seg_new = glyph_of(units);
      default: begin
        unique case (in_view_mode)
          MODE_WORKING: seg_new = hund_glyph & POINT_KEEP;
          MODE_DEBUG:   seg_new = hund_glyph;
          MODE_SET_ONE: seg_new = MARKER_ONE;
          MODE_SET_TWO: seg_new = MARKER_TWO;
          default:      seg_new = ~(8'b1 << phase_nxt);
        endcase
      end
    endcase

    sel_onehot = 8'b1 << ({1'b0, digit_r} + 3'd1);

    seg_hold_nxt = seg_hold_r;
    sel_hold_nxt = sel_hold_r;
    written_nxt  = 1'b0;
    if (digit_r != 2'd0 && mode_known) begin
      written_nxt = 1'b1;
      if (in_view_mode == MODE_PREHEAT && in_shown_value == 16'd0) begin
        seg_hold_nxt = (digit_r != 2'd1) ? BLANK_GLYPH : seg_new;
        sel_hold_nxt = sel_onehot | MIRROR_MASK;
      end else begin
        seg_hold_nxt = seg_new;
        sel_hold_nxt = sel_onehot | (seg_new & MIRROR_MASK);
      end
    end

    digit_nxt = (digit_r == 2'd3) ? 2'd1 : digit_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r     <= '0;
      prescale_r  <= '0;
      phase_r     <= '0;
      seg_hold_r  <= '0;
      sel_hold_r  <= '0;
      written_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        digit_r     <= digit_nxt;
        prescale_r  <= prescale_nxt;
        phase_r     <= phase_nxt;
        seg_hold_r  <= seg_hold_nxt;
        sel_hold_r  <= sel_hold_nxt;
        written_r   <= written_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        // drop the beat once taken
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_byte  = seg_hold_r;
  assign out_select_byte   = sel_hold_r;
  assign out_ports_written = written_r;

endmodule

>>> rtl/sssd_checker.sv
// Port-level checker for the seven-segment scan driver, bound to the top level.
module sssd_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sssd_pkg::mode_t     in_view_mode,
  input logic                out_valid,
  input logic                out_stall,
  input sssd_pkg::seg_t      out_segment_byte,
  input sssd_pkg::seg_t      out_select_byte,
  input logic                out_ports_written
);
  import sssd_pkg::*;

  // A held beat stays and keeps its segment value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_segment_byte))
    else $error("held result beat changed");

  // A written beat enables exactly one of the three digits and nothing in the low bits.
  a_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ports_written |->
      $onehot(out_select_byte[4:2]) && out_select_byte[1:0] == 2'b00
      && out_select_byte[5] == 1'b0)
    else $error("select byte is not a single digit enable");

  // The top select bits always mirror the segment byte on a written beat.
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ports_written |-> out_select_byte[7:6] == out_segment_byte[7:6])
    else $error("select mirror bits disagree with segment byte");

  // An unknown mode never writes the ports.
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_view_mode != MODE_WORKING && in_view_mode != MODE_PREHEAT
      && in_view_mode != MODE_SET_ONE && in_view_mode != MODE_SET_TWO
      && in_view_mode != MODE_DEBUG
    |=> out_valid && !out_ports_written)
    else $error("unknown mode wrote the ports");

endmodule

bind seven_segment_scan_driver sssd_port_checks u_sssd_port_checks (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_view_mode     (in_view_mode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_segment_byte (out_segment_byte),
  .out_select_byte  (out_select_byte),
  .out_ports_written(out_ports_written)
);
